FILE: design/b64d_pkg.sv
// types, codes and the character map shared by the base64url decoder
package b64d_pkg;

   localparam logic [15:0] CAP_RESET = 16'd330;

   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_END_OK  = 2'd1;
   localparam logic [1:0] KIND_END_ERR = 2'd2;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
   localparam logic [2:0] ERR_LENGTH   = 3'd2;
   localparam logic [2:0] ERR_TAIL     = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] byte_count;
      logic [2:0]  error_code;
      logic [7:0]  data_byte;
      logic        final_result;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // six-bit value of one character, ok low when outside the alphabet
   function automatic sextet_type sextet(input logic [7:0] ch);
      sextet_type s;
      s.ok    = 1'b1;
      s.value = 6'd0;
      if (ch >= 8'h41 && ch <= 8'h5a) begin
         s.value = 6'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7a) begin
         s.value = 6'(ch - 8'h61 + 8'd26);
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         s.value = 6'(ch - 8'h30 + 8'd52);
      end else if (ch == 8'h2d) begin
         s.value = 6'd62;
      end else if (ch == 8'h5f) begin
         s.value = 6'd63;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

FILE: design/base64url_strict_decoder.sv
// top level of the unpadded base64url stream decoder
//
// One character is taken per clock cycle while req_tready is high. Each character
// updates the bit accumulator and pushes zero, one or two results (a decoded byte
// and, on the last character, the end status) into a four-entry result
// queue. req_tready is high while the queue holds two results or fewer, so a
// stream runs at one character per cycle as long as the consumer takes results
// at that pace; a message end that also completes a byte adds one result.
// The first error of a message is kept until its end; bytes beyond
// byte_capacity, bad characters, a length of one mod four and nonzero
// trailing bits are reported in the end status.
module base64url_strict_decoder
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_char
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // data_byte, error_code, byte_count, zero pad
   output logic [1:0]  rsp_tuser,   // result_kind
   output logic        rsp_tlast,   // final_result
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // byte_capacity
);

   localparam int QDEPTH = 4;

   logic [15:0] cap_ff;
   logic [5:0]  lb_ff, lb_in;
   logic [2:0]  lc_ff, lc_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [2:0]  err_ff, err_in;

   sextet_type  sx;
   logic [11:0] acc;
   logic [11:0] acc_shift;
   logic [11:0] acc_mask;
   logic [3:0]  cnt_sum;
   logic [2:0]  cnt_rem;
   logic        formed;
   logic        emit;
   logic [2:0]  end_err;
   result_type  byte_res;
   result_type  end_res;
   result_type  slot0;
   logic [1:0]  push_n;
   logic        accept;
   logic        pop;

   result_type  queue_ff [QDEPTH];
   logic [1:0]  wr_ptr_ff;
   logic [1:0]  rd_ptr_ff;
   logic [2:0]  count_ff;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   // per-character decode
   always_comb begin
      sx        = sextet(req_tdata);
      phase_in  = phase_ff + 2'd1;
      acc       = {lb_ff, sx.value};
      cnt_sum   = {1'b0, lc_ff} + 4'd6;
      formed    = cnt_sum[3];
      cnt_rem   = cnt_sum[2:0];
      acc_shift = acc >> cnt_rem;
      acc_mask  = acc & ~(12'hfff << cnt_rem);
      lb_in     = lb_ff;
      lc_in     = lc_ff;
      bytes_in  = bytes_ff;
      err_in    = err_ff;
      emit      = 1'b0;
      if (err_ff == ERR_NONE) begin
         if (!sx.ok) begin
            err_in = ERR_BAD_CHAR;
         end else begin
            if (formed) begin
               if (bytes_ff >= cap_ff) begin
                  err_in = ERR_OVERFLOW;
               end else begin
                  emit     = 1'b1;
                  bytes_in = bytes_ff + 16'd1;
               end
            end
            if (err_in == ERR_NONE) begin
               lb_in = acc_mask[5:0];
               lc_in = cnt_rem;
            end
         end
      end
      end_err = err_in;
      if (end_err == ERR_NONE && phase_in == 2'd1) begin
         end_err = ERR_LENGTH;
      end
      if (end_err == ERR_NONE && lc_in != 3'd0 && lb_in != 6'd0) begin
         end_err = ERR_TAIL;
      end

      byte_res.kind         = KIND_BYTE;
      byte_res.byte_count   = 16'd0;
      byte_res.error_code   = ERR_NONE;
      byte_res.data_byte    = acc_shift[7:0];
      byte_res.final_result = !req_tlast;

      end_res.kind         = (end_err == ERR_NONE) ? KIND_END_OK : KIND_END_ERR;
      end_res.byte_count   = bytes_in;
      end_res.error_code   = end_err;
      end_res.data_byte    = 8'd0;
      end_res.final_result = 1'b1;

      slot0  = emit ? byte_res : end_res;
      push_n = {1'b0, emit} + {1'b0, req_tlast};
   end

   // message state and capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         lb_ff    <= '0;
         lc_ff    <= '0;
         phase_ff <= '0;
         bytes_ff <= '0;
         err_ff   <= ERR_NONE;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (accept) begin
            if (req_tlast) begin
               lb_ff    <= '0;
               lc_ff    <= '0;
               phase_ff <= '0;
               bytes_ff <= '0;
               err_ff   <= ERR_NONE;
            end else begin
               lb_ff    <= lb_in;
               lc_ff    <= lc_in;
               phase_ff <= phase_in;
               bytes_ff <= bytes_in;
               err_ff   <= err_in;
            end
         end
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (accept && push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (accept && push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= end_res;
      end
   end

   // result queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + push_n;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + (accept ? {1'b0, push_n} : 3'd0) - {2'b0, pop};
      end
   end

   assign req_tready = count_ff <= 3'(QDEPTH - 2);
   assign rsp_tvalid = count_ff != 3'd0;
   assign rsp_tdata  = {5'd0, queue_ff[rd_ptr_ff].byte_count,
                        queue_ff[rd_ptr_ff].error_code, queue_ff[rd_ptr_ff].data_byte};
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].final_result;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QDEPTH))
      else $error("result queue overfilled");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == 3'($past(count_ff)
         + ($past(accept) ? {1'b0, $past(push_n)} : 3'd0) - {2'b0, $past(pop)}))
      else $error("result queue count does not follow pushes and pops");

   a_no_byte_after_error: assert property (@(posedge clock) disable iff (reset)
      err_ff != ERR_NONE |-> !emit)
      else $error("byte emitted while an error is pending");

   a_end_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_BYTE |-> rsp_tlast)
      else $error("end status not marked as last result of its item");

   a_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> phase_ff == 2'd0 && bytes_ff == 16'd0 && err_ff == ERR_NONE)
      else $error("message state not cleared after last character");

endmodule
